/* sv/sorted_insert_list_core_defines.svh */
// assertion macros for the sorted insertion list core
`ifndef SORTED_INSERT_LIST_CORE_DEFINES_SVH
`define SORTED_INSERT_LIST_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SIL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sorted_insert_list_core: assertion failed");
`define SIL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sorted_insert_list_core: assertion failed");
`else
`define SIL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SIL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/sil_pkg.sv */
// shared types and constants for the sorted insertion list core
`default_nettype none
package sil_pkg;

    localparam int unsigned SIL_CAPACITY = 32;
    localparam int unsigned SIL_DATA_W   = 32;
    localparam int unsigned SIL_POS_W    = 5;
    localparam int unsigned SIL_CNT_W    = 6;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_EMIT
    } t_sil_state;

    // sideband that travels alongside a list read during emission
    typedef struct packed {
        logic                 vld;
        logic [SIL_POS_W-1:0] pos;
        logic [SIL_CNT_W-1:0] count;
        logic                 dropped;
        logic                 last;
    } t_rd_tag;

endpackage
`default_nettype wire

/* sv/sil_store.sv */
// list storage: one write port, one read port with registered read data
`default_nettype none
module sil_store #(
    parameter int unsigned DEPTH = sil_pkg::SIL_CAPACITY,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [AW-1:0]                       i_waddr,
    input  wire logic signed [sil_pkg::SIL_DATA_W-1:0] i_wdata,
    input  wire logic                                i_re,
    input  wire logic [AW-1:0]                       i_raddr,
    output logic signed [sil_pkg::SIL_DATA_W-1:0]    o_rdata
);

    logic signed [sil_pkg::SIL_DATA_W-1:0] r_mem [DEPTH];
    logic signed [sil_pkg::SIL_DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* sv/sil_seq.sv */
// insertion sequencer: shared signed compare, shift-up walk and list read-out
`default_nettype none
`include "sorted_insert_list_core_defines.svh"
module sil_seq #(
    parameter int unsigned CAPACITY = sil_pkg::SIL_CAPACITY,
    parameter int unsigned AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int unsigned CW       = $clog2(CAPACITY + 1)
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [sil_pkg::SIL_DATA_W-1:0] i_new_value,
    input  wire logic signed [sil_pkg::SIL_DATA_W-1:0] i_rd_data,
    output logic                                       o_busy,
    output logic                                       o_we,
    output logic [AW-1:0]                              o_waddr,
    output logic signed [sil_pkg::SIL_DATA_W-1:0]      o_wdata,
    output logic                                       o_re,
    output logic [AW-1:0]                              o_raddr,
    output sil_pkg::t_rd_tag                           o_tag
);

    sil_pkg::t_sil_state r_state, n_state;
    logic signed [sil_pkg::SIL_DATA_W-1:0] r_value, n_value;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_emit, n_emit;
    logic          r_dropped, n_dropped;
    sil_pkg::t_rd_tag r_tag, n_tag;

    logic [CW-1:0] w_km1;
    logic [CW-1:0] w_emit_nx;
    logic [CW-1:0] w_fill_nx;
    logic          w_less;
    logic          w_emit_last;
    logic [sil_pkg::SIL_POS_W+CW-1:0] w_pos_ext;
    logic [sil_pkg::SIL_CNT_W+CW-1:0] w_cnt_ext;

    assign w_km1      = r_k - CW'(1);
    assign w_emit_nx  = r_emit + CW'(1);
    assign w_fill_nx  = r_fill + CW'(1);
    // the one shared unit: signed compare of the new value with a stored entry
    assign w_less     = (r_value < i_rd_data);
    assign w_emit_last = (w_emit_nx == r_fill);
    // position and count are reported modulo their field widths
    assign w_pos_ext  = {{sil_pkg::SIL_POS_W{1'b0}}, r_emit};
    assign w_cnt_ext  = {{sil_pkg::SIL_CNT_W{1'b0}}, r_fill};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sil_pkg::S_IDLE;
            r_fill  <= '0;
            r_tag   <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_tag   <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value   <= n_value;
        r_k       <= n_k;
        r_emit    <= n_emit;
        r_dropped <= n_dropped;
    end

    always_comb begin
        n_state   = r_state;
        n_value   = r_value;
        n_k       = r_k;
        n_fill    = r_fill;
        n_emit    = r_emit;
        n_dropped = r_dropped;
        o_we      = 1'b0;
        o_waddr   = r_k[AW-1:0];
        o_wdata   = r_value;
        o_re      = 1'b0;
        o_raddr   = w_km1[AW-1:0];
        n_tag     = '0;
        case (r_state)
            sil_pkg::S_IDLE: begin
                if (i_start) begin
                    n_value = i_new_value;
                    n_emit  = '0;
                    if (r_fill == CW'(CAPACITY)) begin
                        n_dropped = 1'b1;
                        n_state   = sil_pkg::S_EMIT;
                    end else begin
                        n_dropped = 1'b0;
                        n_k       = r_fill;
                        n_state   = sil_pkg::S_RD;
                    end
                end
            end
            sil_pkg::S_RD: begin
                if (r_k == '0) begin
                    // walked past every entry: new value is the smallest
                    o_we    = 1'b1;
                    n_fill  = w_fill_nx;
                    n_state = sil_pkg::S_EMIT;
                end else begin
                    o_re    = 1'b1;
                    n_state = sil_pkg::S_CMP;
                end
            end
            sil_pkg::S_CMP: begin
                o_we = 1'b1;
                if (w_less) begin
                    // entry is greater: move it up one place and keep walking down
                    o_wdata = i_rd_data;
                    n_k     = w_km1;
                    n_state = sil_pkg::S_RD;
                end else begin
                    n_fill  = w_fill_nx;
                    n_state = sil_pkg::S_EMIT;
                end
            end
            sil_pkg::S_EMIT: begin
                o_re          = 1'b1;
                o_raddr       = r_emit[AW-1:0];
                n_tag.vld     = 1'b1;
                n_tag.pos     = w_pos_ext[sil_pkg::SIL_POS_W-1:0];
                n_tag.count   = w_cnt_ext[sil_pkg::SIL_CNT_W-1:0];
                n_tag.dropped = r_dropped;
                n_tag.last    = w_emit_last;
                if (w_emit_last) begin
                    n_state = sil_pkg::S_IDLE;
                end else begin
                    n_emit = w_emit_nx;
                end
            end
            default: begin
                n_state = sil_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != sil_pkg::S_IDLE);
    assign o_tag  = r_tag;

    `SIL_ASSERT_NEXT(a_drop_when_full, i_clk, i_rst_n, i_start && !o_busy && r_fill == CW'(CAPACITY), r_dropped && r_state == sil_pkg::S_EMIT)
    `SIL_ASSERT_IMP(a_write_in_range, i_clk, i_rst_n, o_we, r_k < CW'(CAPACITY))
    `SIL_ASSERT_IMP(a_emit_nonempty, i_clk, i_rst_n, r_state == sil_pkg::S_EMIT, r_fill != '0)

endmodule
`default_nettype wire

/* sv/sorted_insert_list_core.sv */
// top level of the sorted insertion list core
// busy per item: the read-out alone when the list is full, else a shift walk over the entries greater
// than the new value, one store write, then a read-out of every entry held after the item
// results stream one per cycle; each passes the store read and tag registers, then the result register
// the shift walk and read-out share one read port of the list store
// reset clears the entry count and strobes; stored values are kept but unused
`default_nettype none
module sorted_insert_list_core #(
    parameter int unsigned CAPACITY = sil_pkg::SIL_CAPACITY
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [sil_pkg::SIL_DATA_W-1:0] i_new_value,
    output logic                                       o_busy,
    output logic                                       o_valid,
    output logic [sil_pkg::SIL_POS_W-1:0]              o_position,
    output logic signed [sil_pkg::SIL_DATA_W-1:0]      o_stored_value,
    output logic [sil_pkg::SIL_CNT_W-1:0]              o_entry_count,
    output logic                                       o_dropped,
    output logic                                       o_last
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic                                  w_we;
    logic [AW-1:0]                         w_waddr;
    logic signed [sil_pkg::SIL_DATA_W-1:0] w_wdata;
    logic                                  w_re;
    logic [AW-1:0]                         w_raddr;
    logic signed [sil_pkg::SIL_DATA_W-1:0] w_rdata;
    sil_pkg::t_rd_tag                      w_tag;

    logic                                  r_valid;
    logic [sil_pkg::SIL_POS_W-1:0]         r_position;
    logic signed [sil_pkg::SIL_DATA_W-1:0] r_stored_value;
    logic [sil_pkg::SIL_CNT_W-1:0]         r_entry_count;
    logic                                  r_dropped;
    logic                                  r_last;

    sil_seq #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_new_value (i_new_value),
        .i_rd_data   (w_rdata),
        .o_busy      (o_busy),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_re        (w_re),
        .o_raddr     (w_raddr),
        .o_tag       (w_tag)
    );

    sil_store #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // result register: one transfer per cycle that the read-out tag marks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tag.vld) begin
            r_position     <= w_tag.pos;
            r_stored_value <= w_rdata;
            r_entry_count  <= w_tag.count;
            r_dropped      <= w_tag.dropped;
            r_last         <= w_tag.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_position     = r_position;
    assign o_stored_value = r_stored_value;
    assign o_entry_count  = r_entry_count;
    assign o_dropped      = r_dropped;
    assign o_last         = r_last;

endmodule
`default_nettype wire
